[hw/rtl/wtvd_pkg.sv]
// Shared types and constants of the windowed tilt variance detector.
`timescale 1ns / 1ps
`default_nettype none

package wtvd_pkg;

    // Widths of the item fields and of the configuration registers.
    localparam int ANGLE_IN_W = 15;
    localparam int SPREAD_W   = 28;
    localparam int WIN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_LIMIT   = 2'd2;

    // Register values after reset.
    localparam logic [WIN_W-1:0]    WINDOW_RESET = 7'd10;
    localparam logic [SPREAD_W-1:0] LIMIT_RESET  = 28'd167772;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_READ    = 8'b0000_0010,
        S_SQUARE  = 8'b0000_0100,
        S_UPDATE  = 8'b0000_1000,
        S_PRODUCT = 8'b0001_0000,
        S_DIFF    = 8'b0010_0000,
        S_DIVIDE  = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } seq_state_t;

    // Step strobes that the sequencer sends to every lane.
    typedef struct packed {
        logic clear;    // empty the window sums
        logic load;     // capture the new sample
        logic fetch;    // read the sample that leaves the window
        logic square;   // square the leaving sample, store the new one
        logic update;   // update sum and sum of squares
        logic product;  // form n*sumsq, sum^2 and n^2
        logic diff;     // form the numerator and set up the divider
        logic step;     // one quotient bit
    } lane_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/wtvd_lane.sv]
// One channel lane: sample history, running sums and a bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none

module wtvd_lane #(
    parameter int MAX_WINDOW = 64,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire wtvd_pkg::lane_ctrl_t                   ctrl,
    input  wire logic [wtvd_pkg::ANGLE_IN_W-1:0]        angle,
    input  wire logic                                   window_full,
    input  wire logic [$clog2(MAX_WINDOW)-1:0]          rd_slot,
    input  wire logic [$clog2(MAX_WINDOW)-1:0]          wr_slot,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]        fill_n,
    output logic      [wtvd_pkg::SPREAD_W-1:0]          spread
);

    localparam int SW  = (ANGLE_BITS < wtvd_pkg::ANGLE_IN_W) ? ANGLE_BITS
                                                               : wtvd_pkg::ANGLE_IN_W;
    localparam int NW  = $clog2(MAX_WINDOW + 1);
    localparam int TW  = SW + NW;
    localparam int PW  = 2 * SW;
    localparam int SQW = 2 * SW + NW;
    localparam int RW  = 2 * SW + 2 * NW;
    localparam int QW  = 2 * SW - 2;

    logic [ANGLE_BITS-1:0] history [MAX_WINDOW];

    logic [31:0]              angle_wide;
    logic [ANGLE_BITS-1:0]    sample_reg;
    logic [ANGLE_BITS-1:0]    old_reg;
    logic signed [SW-1:0]     new_val;
    logic signed [SW-1:0]     old_val;
    logic signed [PW-1:0]     new_prod;
    logic signed [PW-1:0]     old_prod;
    logic [PW-1:0]            new_sq_reg;
    logic [PW-1:0]            old_sq_reg;
    logic signed [TW-1:0]     total_reg;
    logic signed [TW-1:0]     total_next;
    logic signed [TW-1:0]     old_term;
    logic [SQW-1:0]           sq_reg;
    logic [SQW-1:0]           sq_next;
    logic [SQW-1:0]           old_sq_term;
    logic [RW-1:0]            nsq_w;
    logic signed [RW-1:0]     tt_w;
    logic [2*NW-1:0]          den_w;
    logic [RW-1:0]            nsq_reg;
    logic [RW-1:0]            tt_reg;
    logic [2*NW-1:0]          den_reg;
    logic [RW:0]              num_w;
    logic [RW-1:0]            rem_reg;
    logic [RW-1:0]            dv_reg;
    logic [QW-1:0]            q_reg;

    assign angle_wide = {{(32 - wtvd_pkg::ANGLE_IN_W){angle[wtvd_pkg::ANGLE_IN_W-1]}}, angle};
    assign new_val    = signed'(sample_reg[SW-1:0]);
    assign old_val    = signed'(old_reg[SW-1:0]);
    assign new_prod   = new_val * new_val;
    assign old_prod   = old_val * old_val;

    assign old_term    = window_full ? TW'(old_val) : '0;
    assign total_next  = total_reg - old_term + TW'(new_val);
    assign old_sq_term = window_full ? SQW'(old_sq_reg) : '0;
    assign sq_next     = sq_reg - old_sq_term + SQW'(new_sq_reg);

    assign nsq_w = fill_n * sq_reg;
    assign tt_w  = total_reg * total_reg;
    assign den_w = fill_n * fill_n;
    assign num_w = {1'b0, nsq_reg} - {1'b0, tt_reg};

    // History store: one read and one write port, registered read.
    always_ff @(posedge aclk) begin
        if (ctrl.fetch) begin
            old_reg <= history[rd_slot];
        end
        if (ctrl.square) begin
            history[wr_slot] <= sample_reg;
        end
    end

    // Running sums are state of the window and are cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            total_reg <= '0;
            sq_reg    <= '0;
        end else if (ctrl.update) begin
            total_reg <= total_next;
            sq_reg    <= sq_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            sample_reg <= angle_wide[ANGLE_BITS-1:0];
        end
        if (ctrl.fetch) begin
            new_sq_reg <= unsigned'(new_prod);
        end
        if (ctrl.square) begin
            old_sq_reg <= unsigned'(old_prod);
        end
        if (ctrl.product) begin
            nsq_reg <= nsq_w;
            tt_reg  <= unsigned'(tt_w);
            den_reg <= den_w;
        end
        if (ctrl.diff) begin
            // A single sample or a rounding-negative numerator gives zero.
            if (fill_n < NW'(2) || num_w[RW]) begin
                rem_reg <= '0;
            end else begin
                rem_reg <= num_w[RW-1:0];
            end
            dv_reg <= RW'(den_reg) << (QW - 1);
            q_reg  <= '0;
        end else if (ctrl.step) begin
            if (rem_reg >= dv_reg) begin
                rem_reg <= rem_reg - dv_reg;
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
            dv_reg <= dv_reg >> 1;
        end
    end

    assign spread = wtvd_pkg::SPREAD_W'(q_reg);

endmodule

`default_nettype wire

[hw/rtl/wtvd_merge.sv]
// Merging stage: threshold compare of both lanes and the result register.
`timescale 1ns / 1ps
`default_nettype none

module wtvd_merge (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               load,
    input  wire logic [wtvd_pkg::SPREAD_W-1:0]      roll_spread,
    input  wire logic [wtvd_pkg::SPREAD_W-1:0]      pitch_spread,
    input  wire logic [wtvd_pkg::SPREAD_W-1:0]      roll_limit,
    input  wire logic [wtvd_pkg::SPREAD_W-1:0]      pitch_limit,
    output logic                                    out_free,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // Fields from bit 0: roll_spread, pitch_spread, alarm, zero fill.
    output logic [wtvd_pkg::M_TDATA_W-1:0]          m_tdata
);

    localparam int PAD_W = wtvd_pkg::M_TDATA_W - 2 * wtvd_pkg::SPREAD_W - 1;

    logic                           valid_reg;
    logic [wtvd_pkg::SPREAD_W-1:0]  roll_reg;
    logic [wtvd_pkg::SPREAD_W-1:0]  pitch_reg;
    logic                           alarm_reg;
    logic                           alarm_next;

    assign alarm_next = (roll_spread > roll_limit) || (pitch_spread > pitch_limit);
    assign out_free   = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            roll_reg  <= roll_spread;
            pitch_reg <= pitch_spread;
            alarm_reg <= alarm_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, alarm_reg, pitch_reg, roll_reg};

endmodule

`default_nettype wire

[hw/rtl/windowed_tilt_variance_detector.sv]
// Top level of the windowed tilt variance detector: sequencer, registers, lanes.
// Each result is formed by the lane steps and the one-bit-per-cycle divider. A new
// input transaction is taken only once the previous result has been loaded into
// the output register, so the block does not start an item before the last one is done.
// Reset (aresetn low, synchronous): window emptied, window_length back to 10,
// both limits back to 167772, no result pending; the history stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module windowed_tilt_variance_detector #(
    parameter int MAX_WINDOW = 64,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // Fields from bit 0: roll_angle, pitch_angle, zero fill.
    input  wire logic [wtvd_pkg::S_TDATA_W-1:0]        s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // Fields from bit 0: roll_spread, pitch_spread, alarm, zero fill.
    output logic [wtvd_pkg::M_TDATA_W-1:0]             m_tdata,
    input  wire logic                                  cfg_we,
    input  wire logic [wtvd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [wtvd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // Each input transaction is worked on by two identical lanes, one for roll and
    // one for pitch. Each lane reads the sample that leaves the window, updates its
    // running sum and sum of squares, forms n*sumsq - sum^2 and n^2 and then runs a
    // restoring divider that yields one quotient bit per cycle. The merging stage
    // compares both variances against their limits and holds the result in an
    // output register, so a new input transaction is taken while a result waits.

    localparam int SW  = (ANGLE_BITS < wtvd_pkg::ANGLE_IN_W) ? ANGLE_BITS
                                                               : wtvd_pkg::ANGLE_IN_W;
    localparam int QW  = 2 * SW - 2;
    localparam int CW  = $clog2(QW);
    localparam int NW  = $clog2(MAX_WINDOW + 1);
    localparam int SLW = $clog2(MAX_WINDOW);
    localparam int EW  = NW + 1;
    localparam int AW  = (NW > wtvd_pkg::WIN_W) ? NW : wtvd_pkg::WIN_W;

    wtvd_pkg::seq_state_t           state_reg;
    wtvd_pkg::seq_state_t           state_next;
    wtvd_pkg::lane_ctrl_t           ctrl;

    logic [wtvd_pkg::WIN_W-1:0]     window_reg;
    logic [wtvd_pkg::SPREAD_W-1:0]  roll_limit_reg;
    logic [wtvd_pkg::SPREAD_W-1:0]  pitch_limit_reg;
    logic [NW-1:0]                  fill_reg;
    logic [SLW-1:0]                 slot_reg;
    logic [SLW-1:0]                 slot_next;
    logic [SLW-1:0]                 old_slot_reg;
    logic [SLW-1:0]                 old_slot;
    logic                           full_reg;
    logic [CW-1:0]                  div_cnt_reg;

    logic [AW-1:0]                  win_wide;
    logic [AW-1:0]                  win_act;
    logic [NW-1:0]                  win_n;
    logic [EW-1:0]                  slot_e;
    logic [EW-1:0]                  win_e;
    logic [EW-1:0]                  max_e;
    logic [EW-1:0]                  old_e;

    logic                           accept;
    logic                           window_write;
    logic                           out_free;
    logic                           out_load;
    logic [wtvd_pkg::SPREAD_W-1:0]  roll_spread;
    logic [wtvd_pkg::SPREAD_W-1:0]  pitch_spread;

    // Active window: zero behaves as one, large values saturate to MAX_WINDOW.
    assign win_wide = AW'(window_reg);
    always_comb begin
        if (win_wide == '0) begin
            win_act = AW'(1);
        end else if (win_wide > AW'(MAX_WINDOW)) begin
            win_act = AW'(MAX_WINDOW);
        end else begin
            win_act = win_wide;
        end
    end
    assign win_n = win_act[NW-1:0];

    // Slot of the sample that leaves a full window.
    assign slot_e = EW'(slot_reg);
    assign win_e  = EW'(win_n);
    assign max_e  = EW'(MAX_WINDOW);
    always_comb begin
        if (win_e == max_e) begin
            old_e = slot_e;
        end else if (slot_e >= win_e) begin
            old_e = slot_e - win_e;
        end else begin
            old_e = slot_e + max_e - win_e;
        end
    end
    assign old_slot  = old_e[SLW-1:0];
    assign slot_next = (slot_e == max_e - EW'(1)) ? '0 : slot_reg + SLW'(1);

    assign s_tready     = (state_reg == wtvd_pkg::S_IDLE);
    assign accept       = s_tvalid && s_tready;
    assign window_write = cfg_we && (cfg_index == wtvd_pkg::REG_WINDOW_LENGTH);
    assign out_load     = (state_reg == wtvd_pkg::S_DONE) && out_free;

    always_comb begin
        ctrl.clear   = window_write;
        ctrl.load    = accept;
        ctrl.fetch   = (state_reg == wtvd_pkg::S_READ);
        ctrl.square  = (state_reg == wtvd_pkg::S_SQUARE);
        ctrl.update  = (state_reg == wtvd_pkg::S_UPDATE);
        ctrl.product = (state_reg == wtvd_pkg::S_PRODUCT);
        ctrl.diff    = (state_reg == wtvd_pkg::S_DIFF);
        ctrl.step    = (state_reg == wtvd_pkg::S_DIVIDE);
    end

    // Sequencer: one transaction at a time through the lane steps.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wtvd_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = wtvd_pkg::S_READ;
                end
            end
            wtvd_pkg::S_READ:    state_next = wtvd_pkg::S_SQUARE;
            wtvd_pkg::S_SQUARE:  state_next = wtvd_pkg::S_UPDATE;
            wtvd_pkg::S_UPDATE:  state_next = wtvd_pkg::S_PRODUCT;
            wtvd_pkg::S_PRODUCT: state_next = wtvd_pkg::S_DIFF;
            wtvd_pkg::S_DIFF:    state_next = wtvd_pkg::S_DIVIDE;
            wtvd_pkg::S_DIVIDE: begin
                if (div_cnt_reg == '0) begin
                    state_next = wtvd_pkg::S_DONE;
                end
            end
            wtvd_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = wtvd_pkg::S_IDLE;
                end
            end
            default: state_next = wtvd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wtvd_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Divide step counter, loaded as the divider is set up.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (state_reg == wtvd_pkg::S_DIFF) begin
            div_cnt_reg <= CW'(QW - 1);
        end else if (state_reg == wtvd_pkg::S_DIVIDE) begin
            div_cnt_reg <= div_cnt_reg - CW'(1);
        end
    end

    // Transaction bookkeeping captured at accept.
    always_ff @(posedge aclk) begin
        if (accept) begin
            full_reg     <= (fill_reg >= win_n);
            old_slot_reg <= old_slot;
        end
    end

    // Window fill and write position. A window_length write empties the window.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            slot_reg <= '0;
        end else if (window_write) begin
            fill_reg <= '0;
            slot_reg <= '0;
        end else if (state_reg == wtvd_pkg::S_UPDATE) begin
            fill_reg <= full_reg ? win_n : fill_reg + NW'(1);
            slot_reg <= slot_next;
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg      <= wtvd_pkg::WINDOW_RESET;
            roll_limit_reg  <= wtvd_pkg::LIMIT_RESET;
            pitch_limit_reg <= wtvd_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wtvd_pkg::REG_WINDOW_LENGTH: window_reg      <= cfg_data[wtvd_pkg::WIN_W-1:0];
                wtvd_pkg::REG_ROLL_LIMIT:    roll_limit_reg  <= cfg_data;
                wtvd_pkg::REG_PITCH_LIMIT:   pitch_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    wtvd_lane #(
        .MAX_WINDOW (MAX_WINDOW),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_roll_lane (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .angle       (s_tdata[wtvd_pkg::ANGLE_IN_W-1:0]),
        .window_full (full_reg),
        .rd_slot     (old_slot_reg),
        .wr_slot     (slot_reg),
        .fill_n      (fill_reg),
        .spread      (roll_spread)
    );

    wtvd_lane #(
        .MAX_WINDOW (MAX_WINDOW),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_pitch_lane (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .angle       (s_tdata[2*wtvd_pkg::ANGLE_IN_W-1:wtvd_pkg::ANGLE_IN_W]),
        .window_full (full_reg),
        .rd_slot     (old_slot_reg),
        .wr_slot     (slot_reg),
        .fill_n      (fill_reg),
        .spread      (pitch_spread)
    );

    wtvd_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (out_load),
        .roll_spread  (roll_spread),
        .pitch_spread (pitch_spread),
        .roll_limit   (roll_limit_reg),
        .pitch_limit  (pitch_limit_reg),
        .out_free     (out_free),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    // The window never holds more samples than the active window length.
    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= win_n)
        else $error("fill count exceeds active window");

    // The write position always stays inside the history store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        EW'(slot_reg) < max_e)
        else $error("write slot outside history store");

    // The divider only runs after its setup step or a previous divide step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wtvd_pkg::S_DIVIDE |->
            ($past(state_reg) == wtvd_pkg::S_DIFF || $past(state_reg) == wtvd_pkg::S_DIVIDE))
        else $error("divider entered out of sequence");

    // A new result is only presented after the sequencer finished a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == wtvd_pkg::S_DONE)
        else $error("result presented without finished transaction");

    // An accepted input transaction always starts the lane steps next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == wtvd_pkg::S_READ)
        else $error("accepted transaction did not start");

endmodule

`default_nettype wire

[tb/sv/tb_windowed_tilt_variance_detector.sv]
// Self-checking testbench for the windowed tilt variance detector.
`timescale 1ns / 1ps

module tb_windowed_tilt_variance_detector;

    // Depth of the sample stores at the default parameters of the block.
    localparam int MAX_WIN = 64;
    // Largest magnitude of an angle field, pi in Q3.12.
    localparam int ANGLE_MAX = 12868;
    // Largest variance that angles within +-ANGLE_MAX can produce.
    localparam logic [wtvd_pkg::SPREAD_W-1:0] LIMIT_HIGH = 28'd165585424;
    localparam logic [wtvd_pkg::SPREAD_W-1:0] SPREAD_CAP = 28'hFFFFFFF;
    // Register index that the block does not implement.
    localparam logic [wtvd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // Margin waited after the last owed result before the registers are touched.
    localparam int SETTLE_CYCLES = 60;
    // The run is cut off as hung once the cycle count passes this limit.
    localparam int CYCLE_LIMIT = 300000;

    // One result of the block, laid out as the low bits of m_tdata.
    typedef struct packed {
        logic                          alarm;
        logic [wtvd_pkg::SPREAD_W-1:0] pitch_spread;
        logic [wtvd_pkg::SPREAD_W-1:0] roll_spread;
    } spread_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // Fields from bit 0: roll_angle, pitch_angle, zero fill.
    logic [wtvd_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // Fields from bit 0: roll_spread, pitch_spread, alarm, zero fill.
    logic [wtvd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            cfg_we = 1'b0;
    logic [wtvd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wtvd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    windowed_tilt_variance_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Results still owed by the block, oldest first.
    spread_t spread_queue[$];

    // Run bookkeeping.
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int cycle_count = 0;

    // Idling controls. When an enable is low that side never waits on its own.
    bit sender_idle = 1'b1;
    bit receiver_idle = 1'b1;
    // Set by the stall test; the receiver process waits that long and then clears it.
    int hold_cycles = 0;

    // Predictor state: a private copy of the window stores, the running sums
    // and the three configuration registers.
    int          roll_hist[MAX_WIN];
    int          pitch_hist[MAX_WIN];
    int          fill_level;
    int          next_slot;
    longint      roll_sum;
    longint      pitch_sum;
    longint      roll_sq_sum;
    longint      pitch_sq_sum;
    logic [wtvd_pkg::WIN_W-1:0]    window_reg;
    logic [wtvd_pkg::SPREAD_W-1:0] roll_limit_reg;
    logic [wtvd_pkg::SPREAD_W-1:0] pitch_limit_reg;

    function automatic void clear_window();
        fill_level   = 0;
        next_slot    = 0;
        roll_sum     = 0;
        pitch_sum    = 0;
        roll_sq_sum  = 0;
        pitch_sq_sum = 0;
    endfunction

    // Population variance floor((n*sumsq - sum^2) / n^2), zero below two samples.
    function automatic logic [wtvd_pkg::SPREAD_W-1:0] window_variance(longint sum,
                                                                      longint sq, int n);
        longint num;
        longint quot;
        if (n < 2) begin
            return '0;
        end
        num = longint'(n) * sq - sum * sum;
        if (num <= 0) begin
            return '0;
        end
        quot = num / (longint'(n) * longint'(n));
        if (quot > longint'(SPREAD_CAP)) begin
            quot = longint'(SPREAD_CAP);
        end
        return quot[wtvd_pkg::SPREAD_W-1:0];
    endfunction

    // Advances the predictor by one sample pair and returns the result it owes.
    function automatic spread_t predict_spread(logic signed [wtvd_pkg::ANGLE_IN_W-1:0] roll,
                                               logic signed [wtvd_pkg::ANGLE_IN_W-1:0] pitch);
        int      win;
        int      oldest;
        int      r;
        int      p;
        spread_t res;
        win = int'(window_reg);
        if (win == 0) begin
            win = 1;
        end
        if (win > MAX_WIN) begin
            win = MAX_WIN;
        end
        r = int'(roll);
        p = int'(pitch);
        // A full window first drops its oldest sample from the sums.
        if (fill_level >= win) begin
            oldest = (next_slot + MAX_WIN - (win % MAX_WIN)) % MAX_WIN;
            roll_sum     -= roll_hist[oldest];
            pitch_sum    -= pitch_hist[oldest];
            roll_sq_sum  -= longint'(roll_hist[oldest]) * roll_hist[oldest];
            pitch_sq_sum -= longint'(pitch_hist[oldest]) * pitch_hist[oldest];
            fill_level = win - 1;
        end
        roll_hist[next_slot]  = r;
        pitch_hist[next_slot] = p;
        roll_sum     += r;
        pitch_sum    += p;
        roll_sq_sum  += longint'(r) * r;
        pitch_sq_sum += longint'(p) * p;
        fill_level++;
        next_slot = (next_slot + 1) % MAX_WIN;
        res.roll_spread  = window_variance(roll_sum, roll_sq_sum, fill_level);
        res.pitch_spread = window_variance(pitch_sum, pitch_sq_sum, fill_level);
        res.alarm = (res.roll_spread > roll_limit_reg) || (res.pitch_spread > pitch_limit_reg);
        return res;
    endfunction

    function automatic int clamp_angle(int v);
        if (v > ANGLE_MAX) begin
            return ANGLE_MAX;
        end
        if (v < -ANGLE_MAX) begin
            return -ANGLE_MAX;
        end
        return v;
    endfunction

    // The run is cut off if it takes far longer than the slowest correct run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, spread_queue.size());
            $display("tb_windowed_tilt_variance_detector NOT OK");
            $finish;
        end
    end

    // Offers one sample pair after a random gap and waits for the transaction.
    // On return s_tvalid is still high, so the next call can follow at once
    // without lowering it; settle() lowers it when the stream pauses.
    task automatic send_tilt(int roll, int pitch);
        int      gap;
        spread_t owed;
        gap = sender_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, wtvd_pkg::ANGLE_IN_W'(pitch), wtvd_pkg::ANGLE_IN_W'(roll)};
        do @(posedge aclk); while (!s_tready);
        owed = predict_spread(wtvd_pkg::ANGLE_IN_W'(roll), wtvd_pkg::ANGLE_IN_W'(pitch));
        spread_queue.insert(spread_queue.size(), owed);
        items_sent++;
    endtask

    // Stops the stream and waits until every owed result has come, plus a margin,
    // so that the block is idle before its registers are touched.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (spread_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One-cycle register write; the predictor follows after the edge that takes it.
    task automatic write_register(logic [wtvd_pkg::CFG_IDX_W-1:0] idx,
                                  logic [wtvd_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        case (idx)
            wtvd_pkg::REG_WINDOW_LENGTH: begin
                window_reg = value[wtvd_pkg::WIN_W-1:0];
                clear_window();
            end
            wtvd_pkg::REG_ROLL_LIMIT:  roll_limit_reg  = value[wtvd_pkg::SPREAD_W-1:0];
            wtvd_pkg::REG_PITCH_LIMIT: pitch_limit_reg = value[wtvd_pkg::SPREAD_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic compare_field(string label, logic [wtvd_pkg::SPREAD_W-1:0] want,
                                 logic [wtvd_pkg::SPREAD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    // Receiver: waits a random number of cycles before each result while idling
    // is enabled, honors a long hold-off when the stall test asks for one, and
    // checks every accepted result against the oldest prediction.
    initial begin : result_checker
        int      gap;
        spread_t got;
        spread_t want;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            gap = receiver_idle ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = m_tdata[$bits(spread_t)-1:0];
            if (spread_queue.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %h",
                         $time, got);
                mismatches++;
            end else begin
                want = spread_queue[0];
                spread_queue.delete(0);
                compare_field("roll_spread", want.roll_spread, got.roll_spread);
                compare_field("pitch_spread", want.pitch_spread, got.pitch_spread);
                compare_field("alarm", wtvd_pkg::SPREAD_W'(want.alarm),
                              wtvd_pkg::SPREAD_W'(got.alarm));
                results_checked++;
            end
        end
    end

    // Reset settings: one sample gives zero, then roll swings between its
    // extremes while pitch stays constant, running past the ten-sample window
    // so that the oldest sample starts to leave the sums.
    task automatic test_reset_window();
        int i;
        send_tilt(0, 0);
        for (i = 0; i < 10; i++) begin
            send_tilt((i % 2 == 0) ? ANGLE_MAX : -ANGLE_MAX, 5);
        end
        settle();
    endtask

    // Register corners: a zero window acts as one, a window above the store
    // depth saturates, the upper data bits of the window write are ignored,
    // a zero limit only fires on a nonzero variance, and the unused index
    // changes nothing.
    task automatic test_register_extremes();
        write_register(wtvd_pkg::REG_WINDOW_LENGTH, 28'd0);
        send_tilt(ANGLE_MAX, -ANGLE_MAX);
        send_tilt(-ANGLE_MAX, ANGLE_MAX);
        settle();
        write_register(wtvd_pkg::REG_WINDOW_LENGTH, 28'hABCDEFF);
        send_tilt(-ANGLE_MAX, -ANGLE_MAX);
        send_tilt(ANGLE_MAX, ANGLE_MAX);
        settle();
        write_register(wtvd_pkg::REG_WINDOW_LENGTH, 28'd2);
        write_register(wtvd_pkg::REG_ROLL_LIMIT, 28'd0);
        write_register(wtvd_pkg::REG_PITCH_LIMIT, LIMIT_HIGH);
        send_tilt(7, 7);
        send_tilt(7, 7);
        send_tilt(8, ANGLE_MAX);
        settle();
        write_register(REG_UNUSED, SPREAD_CAP);
        write_register(wtvd_pkg::REG_PITCH_LIMIT, SPREAD_CAP);
        send_tilt(8, -ANGLE_MAX);
        settle();
    endtask

    // Random phases, each with its own window and limits. The samples wander
    // around a slowly drifting level with a per-phase spread, so that the
    // variances move across the limits; a few samples jump to the extremes.
    task automatic test_random_traffic();
        int phase;
        int i;
        int level;
        int amp;
        int roll;
        int pitch;
        logic [wtvd_pkg::CFG_DATA_W-1:0] win_value;
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       win_value = 28'd64;
                1:       win_value = 28'd1;
                2:       win_value = 28'd100;
                3:       win_value = {21'($urandom), 7'($urandom_range(2, 64))};
                default: win_value = 28'($urandom_range(2, 64));
            endcase
            write_register(wtvd_pkg::REG_WINDOW_LENGTH, win_value);
            if (phase == 4) begin
                write_register(wtvd_pkg::REG_ROLL_LIMIT, SPREAD_CAP);
                write_register(wtvd_pkg::REG_PITCH_LIMIT, 28'd0);
            end else begin
                write_register(wtvd_pkg::REG_ROLL_LIMIT, 28'($urandom_range(0, 3000000)));
                write_register(wtvd_pkg::REG_PITCH_LIMIT, 28'($urandom_range(0, 3000000)));
            end
            case ($urandom_range(0, 3))
                0:       amp = 8;
                1:       amp = 200;
                2:       amp = 3000;
                default: amp = ANGLE_MAX;
            endcase
            // One phase runs with no idling on either side.
            sender_idle   = (phase != 5);
            receiver_idle = (phase != 5);
            level = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
            for (i = 0; i < 95; i++) begin
                level = clamp_angle(level + int'($urandom_range(0, 400)) - 200);
                if ($urandom_range(0, 9) == 0) begin
                    roll  = $urandom_range(0, 1) ? ANGLE_MAX : -ANGLE_MAX;
                    pitch = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
                end else begin
                    roll  = clamp_angle(level + int'($urandom_range(0, 2 * amp)) - amp);
                    pitch = clamp_angle(-level + int'($urandom_range(0, 2 * amp)) - amp);
                end
                send_tilt(roll, pitch);
            end
            settle();
        end
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    // Output stall: the receiver holds off for a long stretch while the sender
    // offers back-to-back transactions, so the block fills and stops taking input.
    task automatic test_output_stall();
        int i;
        write_register(wtvd_pkg::REG_WINDOW_LENGTH, 28'd16);
        write_register(wtvd_pkg::REG_ROLL_LIMIT, 28'd500000);
        write_register(wtvd_pkg::REG_PITCH_LIMIT, 28'd500000);
        sender_idle = 1'b0;
        hold_cycles = 300;
        for (i = 0; i < 30; i++) begin
            send_tilt(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX,
                      int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
        end
        sender_idle = 1'b1;
        settle();
    endtask

    initial begin
        window_reg      = wtvd_pkg::WINDOW_RESET;
        roll_limit_reg  = wtvd_pkg::LIMIT_RESET;
        pitch_limit_reg = wtvd_pkg::LIMIT_RESET;
        clear_window();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_window();
        test_register_extremes();
        test_random_traffic();
        test_output_stall();
        settle();

        $display("Covered reset settings, window and limit corners, random phases and a long output stall.");
        $display("Sent %0d samples, checked %0d results, made %0d register writes, %0d mismatches.",
                 items_sent, results_checked, cfg_writes, mismatches);
        if (mismatches == 0 && spread_queue.size() == 0) begin
            $display("tb_windowed_tilt_variance_detector OK");
        end else begin
            $display("tb_windowed_tilt_variance_detector NOT OK");
        end
        $finish;
    end

endmodule
